FILE: src/servo_position_estimator_macros.svh
// Assertion macros used by the servo position estimator sequencer.
`ifndef SERVO_POSITION_ESTIMATOR_MACROS_SVH
`define SERVO_POSITION_ESTIMATOR_MACROS_SVH
`ifndef SYNTH
`define SPE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spe: same-cycle check failed");
`define SPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spe: next-cycle check failed");
`else
`define SPE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/spe_pkg.sv
// Types and constants shared by the servo position estimator modules.
`timescale 1ns / 1ps
`default_nettype none

package spe_pkg;

    localparam int unsigned COEF_W = 16;
    localparam int unsigned DT_W   = 16;
    localparam int unsigned MAG_W  = 10;
    localparam int unsigned EST_W  = 13;
    localparam int unsigned P0_W   = MAG_W + COEF_W;
    localparam int unsigned PROD_W = P0_W + DT_W;
    localparam int unsigned SUM_W  = P0_W + 2;

    localparam logic [9:0]  POS_MAX        = 10'd1023;
    localparam logic [9:0]  POS_MIN        = 10'd0;
    localparam logic [9:0]  BAND_LOW       = 10'd100;
    localparam logic [9:0]  BAND_HIGH      = 10'd923;
    localparam logic [10:0] FOLD_TOP       = 11'd1193;
    localparam logic [10:0] FOLD_WRAP      = 11'd1023;
    localparam logic signed [EST_W-1:0] EST_FOLD_TOP  = 13'sd1193;
    localparam logic signed [EST_W-1:0] EST_FOLD_SPAN = -13'sd170;
    localparam logic signed [SUM_W-1:0] SUM_EST_MAX   = 28'sd4095;
    localparam logic signed [SUM_W-1:0] SUM_EST_MIN   = -28'sd4096;
    localparam logic signed [EST_W-1:0] EST_MAX       = 13'sd4095;
    localparam logic signed [EST_W-1:0] EST_MIN       = -13'sd4096;
    localparam logic [DT_W-1:0] DT_MAX     = 16'hFFFF;
    localparam logic [COEF_W-1:0] COEF_RESET = 16'd124;

    localparam logic REG_RATE_COEF = 1'b0;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ENTER  = 2'd1,
        MODE_WAIT   = 2'd2
    } t_spe_mode;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_DT   = 2'd1,
        ST_MUL  = 2'd2,
        ST_FIN  = 2'd3
    } t_spe_state;

    typedef struct packed {
        logic [3:0]  actuator_index;
        logic [9:0]  measured_position;
        logic [10:0] speed_word;
        logic        direction;
        logic [31:0] time_ms;
    } t_spe_in;

    typedef struct packed {
        logic [10:0] estimated_position;
        logic        valid_angle;
        logic [1:0]  estimate_mode;
    } t_spe_out;

    typedef struct packed {
        logic [1:0]              mode;
        logic signed [EST_W-1:0] est;
        logic [31:0]             last_time;
    } t_spe_entry;

    typedef struct packed {
        logic accept;
        logic calc_dt;
        logic mul;
        logic finish;
    } t_spe_cmd;

    typedef struct packed {
        logic out_full;
    } t_spe_status;

endpackage

`default_nettype wire

FILE: src/spe_ctrl.sv
// Sequencer for the servo position estimator: accept, elapsed time, multiply, write back.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_position_estimator_macros.svh"

module spe_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire                  i_out_ready,
    input  spe_pkg::t_spe_status i_status,
    output spe_pkg::t_spe_cmd    o_cmd
);
    import spe_pkg::*;

    t_spe_state r_state;
    t_spe_state n_state;
    logic       w_room;

    assign w_room = !i_status.out_full || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DT;
                end
            end
            ST_DT: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_room) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.accept   = 1'b0;
        o_cmd.calc_dt  = 1'b0;
        o_cmd.mul      = 1'b0;
        o_cmd.finish   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_DT: begin
                o_cmd.calc_dt = 1'b1;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_FIN: begin
                o_cmd.finish = w_room;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    `SPE_ASSERT_NEXT(a_accept_to_dt, i_clk, i_rst_n, o_cmd.accept, r_state == ST_DT)
    `SPE_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, (r_state == ST_FIN) && i_status.out_full && !i_out_ready, r_state == ST_FIN)
    `SPE_ASSERT_NEXT(a_finish_to_idle, i_clk, i_rst_n, o_cmd.finish, o_in_ready && !o_cmd.finish)

endmodule

`default_nettype wire

FILE: src/spe_datapath.sv
// Datapath of the servo position estimator: state memory, dead reckoning and output register.
`timescale 1ns / 1ps
`default_nettype none

module spe_datapath #(
    parameter int unsigned ACTUATORS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  spe_pkg::t_spe_cmd    i_cmd,
    output spe_pkg::t_spe_status o_status,
    input  spe_pkg::t_spe_in     i_in_word,
    input  wire [15:0]           i_coef,
    input  wire                  i_out_ready,
    output logic                 o_out_valid,
    output spe_pkg::t_spe_out    o_out_word
);
    import spe_pkg::*;

    localparam int unsigned IDX_W = (ACTUATORS > 1) ? $clog2(ACTUATORS) : 1;
    localparam int unsigned IN_IDX_N = 16;

    logic [IDX_W-1:0] w_idx_tab [IN_IDX_N];

    for (genvar v = 0; v < IN_IDX_N; v++) begin : g_idx_tab
        localparam int unsigned ModV = v % ACTUATORS;
        assign w_idx_tab[v] = IDX_W'(ModV);
    end

    t_spe_entry       r_mem [ACTUATORS];
    logic [ACTUATORS-1:0] r_valid;

    logic [IDX_W-1:0]   w_idx;
    logic [IDX_W-1:0]   r_idx;
    logic [9:0]         r_pos;
    logic               r_spd_sign;
    logic               r_dir;
    logic [31:0]        r_now;
    logic [P0_W-1:0]    r_p0;
    t_spe_entry         r_ent;
    logic               r_ent_vld;
    logic [DT_W-1:0]    r_dt;
    logic [PROD_W-1:0]  r_prod;

    t_spe_entry         w_ent;
    logic [31:0]        w_diff;
    logic [P0_W-1:0]    w_mag;
    logic               w_neg;
    logic signed [SUM_W-1:0] w_est_ext;
    logic signed [SUM_W-1:0] w_mag_ext;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [EST_W-1:0] w_sat;
    logic signed [EST_W-1:0] w_pos_est;
    logic signed [EST_W-1:0] n_est;
    logic [1:0]         n_mode;
    logic [10:0]        w_fold;
    logic               w_leave_dir;
    t_spe_entry         n_ent;
    logic               r_out_valid;
    t_spe_out           r_out_word;

    assign w_idx = w_idx_tab[i_in_word.actuator_index];
    assign w_ent = r_ent_vld ? r_ent : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_ent <= r_mem[w_idx];
        end
        if (i_cmd.finish) begin
            r_mem[r_idx] <= n_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_valid[r_idx] <= 1'b1;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx      <= w_idx;
            r_ent_vld  <= r_valid[w_idx];
            r_pos      <= i_in_word.measured_position;
            r_spd_sign <= i_in_word.speed_word[10];
            r_dir      <= i_in_word.direction;
            r_now      <= i_in_word.time_ms;
            r_p0       <= P0_W'(i_in_word.speed_word[9:0]) * P0_W'(i_coef);
        end
        if (i_cmd.calc_dt) begin
            r_dt <= (w_diff[31:DT_W] != '0) ? DT_MAX : w_diff[DT_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_dt) * PROD_W'(r_p0);
        end
        if (i_cmd.finish) begin
            r_out_word.estimated_position <= w_fold;
            r_out_word.valid_angle        <= (n_mode == MODE_NORMAL);
            r_out_word.estimate_mode      <= n_mode;
        end
    end

    assign w_diff = r_now - w_ent.last_time;

    assign w_mag     = r_prod[PROD_W-1:DT_W];
    assign w_neg     = r_dir ^ r_spd_sign;
    assign w_est_ext = SUM_W'(w_ent.est);
    assign w_mag_ext = signed'({2'b00, w_mag});
    assign w_sum     = w_neg ? (w_est_ext - w_mag_ext) : (w_est_ext + w_mag_ext);
    assign w_pos_est = signed'({3'b000, r_pos});
    assign w_leave_dir = (!r_dir && (r_pos != POS_MIN)) || (r_dir && (r_pos != POS_MAX));

    always_comb begin
        if (w_sum > SUM_EST_MAX) begin
            w_sat = EST_MAX;
        end else if (w_sum < SUM_EST_MIN) begin
            w_sat = EST_MIN;
        end else begin
            w_sat = w_sum[EST_W-1:0];
        end
    end

    always_comb begin
        n_mode = w_ent.mode;
        n_est  = w_ent.est;
        case (w_ent.mode)
            MODE_NORMAL: begin
                n_est = w_pos_est;
                if ((!r_dir && (r_pos == POS_MAX)) || (r_dir && (r_pos == POS_MIN))) begin
                    n_mode = MODE_ENTER;
                end
            end
            MODE_ENTER: begin
                n_est = w_sat;
                if ((!r_dir && (r_pos == POS_MIN)) || (r_dir && (r_pos == POS_MAX))) begin
                    n_mode = MODE_WAIT;
                end
            end
            MODE_WAIT: begin
                n_est = w_sat;
                if (w_leave_dir && ((r_pos <= BAND_LOW) || (r_pos >= BAND_HIGH))) begin
                    n_mode = MODE_NORMAL;
                    n_est  = w_pos_est;
                end
            end
            default: begin
                n_mode = w_ent.mode;
            end
        endcase
    end

    always_comb begin
        if (n_est > EST_FOLD_TOP) begin
            w_fold = FOLD_TOP;
        end else if (n_est < EST_FOLD_SPAN) begin
            w_fold = FOLD_WRAP;
        end else if (n_est < 0) begin
            w_fold = 11'(EST_FOLD_TOP + n_est);
        end else begin
            w_fold = n_est[10:0];
        end
    end

    always_comb begin
        n_ent.mode      = n_mode;
        n_ent.est       = n_est;
        n_ent.last_time = r_now;
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

endmodule

`default_nettype wire

FILE: src/servo_position_estimator.sv
// Servo position estimator top level: register port, sequencer and datapath.
// An accepted word passes the elapsed-time and multiply steps and reaches the output register at write-back.
// One word is taken at a time, the next only after write-back: memory read, elapsed time, multiply
// and write-back run in turn on the per-actuator state memory.
// A waiting result does not block the next input; a full output only holds the write-back.
// Synchronous reset sets every actuator to normal mode, estimate 0, time 0 and the coefficient to 124.
`timescale 1ns / 1ps
`default_nettype none

module servo_position_estimator #(
    parameter int unsigned ACTUATORS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  spe_pkg::t_spe_in  i_in_word,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output spe_pkg::t_spe_out o_out_word,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [2:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import spe_pkg::*;

    logic [COEF_W-1:0] r_coef;
    t_spe_cmd          w_cmd;
    t_spe_status       w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= COEF_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_RATE_COEF)) begin
            r_coef <= pwdata[COEF_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE_COEF) ? {{(32 - COEF_W){1'b0}}, r_coef} : '0;

    spe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    spe_datapath #(
        .ACTUATORS (ACTUATORS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_coef      (r_coef),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
